// ===== design/gdl_pkg.sv =====
`default_nettype none

package gdl_pkg;

  localparam int OpW         = 3;
  localparam int CountW      = 2;
  localparam int ValueW      = 17;
  localparam int OutW        = 6;
  localparam int NumLanes    = 3;
  localparam int QueueDepth  = 2;

  // Weights are carried as Q30 accumulators before the final rounding.
  localparam int AccFrac     = 30;
  localparam int AccW        = AccFrac + 1;
  localparam int NumFracBits = 8;
  localparam int FracIdxW    = $clog2(NumFracBits);
  localparam int NumMulStages = NumFracBits + 1;
  localparam int NumDivBits  = 5;

  localparam int IdxW        = 5;
  localparam int TenthW      = 4;
  localparam int ExpIntLen   = 18;
  localparam int PlStep      = 10;
  localparam int PlLimit     = ExpIntLen * PlStep;
  localparam int GlLimit     = ExpIntLen << NumFracBits;
  localparam int Recip10     = 205;
  localparam int Recip10Shift = 11;
  localparam int Recip10ProdW = 16;

  localparam logic [2*AccW-1:0] Q30Half = 62'(1) << (AccFrac - 1);

  localparam logic signed [OutW-1:0] TenthsMissing = -6'sd10;
  localparam logic signed [OutW-1:0] TenthsZero    = 6'sd0;

  typedef enum logic [OpW-1:0] {
    OpPl     = 3'd0,
    OpGl     = 3'd1,
    OpGt     = 3'd2,
    OpMono   = 3'd3,
    OpNoData = 3'd4
  } op_e;

  typedef enum logic {
    KindFixed      = 1'b0,
    KindLikelihood = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic signed [OutW-1:0] fixed_tenths;
  } ctl_t;

  typedef struct packed {
    ctl_t                                  ctl;
    logic [NumLanes-1:0]                   live;
    logic [NumLanes-1:0][IdxW-1:0]         int_idx;
    logic [NumLanes-1:0][TenthW-1:0]       tenth_idx;
    logic [NumLanes-1:0][NumFracBits-1:0]  frac_bits;
  } job_t;

  // exp(-k) in Q30 for whole steps k.
  function automatic logic [AccW-1:0] exp_int(input logic [IdxW-1:0] idx);
    logic [AccW-1:0] val;
    case (idx)
      5'd0:    val = 31'd1073741824;
      5'd1:    val = 31'd395007542;
      5'd2:    val = 31'd145315154;
      5'd3:    val = 31'd53458458;
      5'd4:    val = 31'd19666267;
      5'd5:    val = 31'd7234816;
      5'd6:    val = 31'd2661540;
      5'd7:    val = 31'd979126;
      5'd8:    val = 31'd360200;
      5'd9:    val = 31'd132510;
      5'd10:   val = 31'd48748;
      5'd11:   val = 31'd17933;
      5'd12:   val = 31'd6597;
      5'd13:   val = 31'd2427;
      5'd14:   val = 31'd893;
      5'd15:   val = 31'd328;
      5'd16:   val = 31'd121;
      5'd17:   val = 31'd44;
      default: val = '0;
    endcase
    return val;
  endfunction

  // exp(-r/10) in Q30.
  function automatic logic [AccW-1:0] exp_tenth(input logic [TenthW-1:0] idx);
    logic [AccW-1:0] val;
    case (idx)
      4'd0:    val = 31'd1073741824;
      4'd1:    val = 31'd971561780;
      4'd2:    val = 31'd879105452;
      4'd3:    val = 31'd795447508;
      4'd4:    val = 31'd719750669;
      4'd5:    val = 31'd651257337;
      4'd6:    val = 31'd589282007;
      4'd7:    val = 31'd533204410;
      4'd8:    val = 31'd482463302;
      4'd9:    val = 31'd436550848;
      default: val = '0;
    endcase
    return val;
  endfunction

  // exp(-2^i/256) in Q30.
  function automatic logic [AccW-1:0] exp_bit(input logic [FracIdxW-1:0] idx);
    logic [AccW-1:0] val;
    case (idx)
      3'd0:    val = 31'd1069555701;
      3'd1:    val = 31'd1065385899;
      3'd2:    val = 31'd1057095000;
      3'd3:    val = 31'd1040706261;
      3'd4:    val = 31'd1008687095;
      3'd5:    val = 31'd947573834;
      3'd6:    val = 31'd836230973;
      3'd7:    val = 31'd651257337;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Q30 product, rounded half up. Operands never exceed 1.0, so neither does the result.
  function automatic logic [AccW-1:0] q30_mul(input logic [AccW-1:0] a,
                                              input logic [AccW-1:0] b);
    logic [2*AccW-1:0] prod;
    prod = (62'(a) * 62'(b)) + Q30Half;
    return prod[AccFrac +: AccW];
  endfunction

endpackage

`default_nettype wire

// ===== design/genotype_dosage_from_likelihoods_core.sv =====
`default_nettype none

// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    operation_i, value_count_i, value_a_i..value_c_i
// out      out_valid_o / out_ready_i  dosage_tenths_o
//
// One request per cycle sustained while no result is held at the output; each request
// passes through the nine-stage exponent multiplier chain and the five-stage divider.
// rst_ni clears the queue pointers and all stage valid bits asynchronously.
// A held result freezes the back pipeline; the two-entry queue takes up to two more
// requests before in_ready_o falls. in_ready_o depends only on the queue fill.

module genotype_dosage_from_likelihoods_core #(
  parameter int WEIGHT_FRAC_BITS = 16,
  parameter int MAX_VALUES       = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gdl_pkg::OpW-1:0]           operation_i,
  input  logic [gdl_pkg::CountW-1:0]        value_count_i,
  input  logic signed [gdl_pkg::ValueW-1:0] value_a_i,
  input  logic signed [gdl_pkg::ValueW-1:0] value_b_i,
  input  logic signed [gdl_pkg::ValueW-1:0] value_c_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [gdl_pkg::OutW-1:0]   dosage_tenths_o
);

  gdl_pkg::job_t front_job;
  gdl_pkg::job_t q_job;
  logic          q_pop_valid;
  logic          back_ready;

  gdl_front #(
    .MAX_VALUES (MAX_VALUES)
  ) u_front (
    .operation_i   (operation_i),
    .value_count_i (value_count_i),
    .value_a_i     (value_a_i),
    .value_b_i     (value_b_i),
    .value_c_i     (value_c_i),
    .job_o         (front_job)
  );

  gdl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_job_i   (front_job),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (back_ready),
    .pop_job_o    (q_job)
  );

  gdl_back #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .MAX_VALUES       (MAX_VALUES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (q_pop_valid),
    .job_i           (q_job),
    .job_ready_o     (back_ready),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .dosage_tenths_o (dosage_tenths_o)
  );

`ifndef SYNTH
  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_valid && !back_ready |=> q_pop_valid)
    else $error("queued request lost while the back end was stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !back_ready |-> out_valid_o && !out_ready_i)
    else $error("back end stalled without a held result");

  a_full_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_pop_valid)
    else $error("input blocked while the queue offers nothing");

  a_fixed_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_valid && q_job.ctl.kind == gdl_pkg::KindFixed |->
      q_job.ctl.fixed_tenths == gdl_pkg::TenthsMissing ||
      q_job.ctl.fixed_tenths == gdl_pkg::TenthsZero ||
      q_job.ctl.fixed_tenths == 6'sd10 ||
      q_job.ctl.fixed_tenths == 6'sd20 ||
      q_job.ctl.fixed_tenths == 6'sd30)
    else $error("classified request carries an impossible fixed dosage");
`endif

endmodule

`default_nettype wire

// ===== design/gdl_front.sv =====
`default_nettype none

module gdl_front #(
  parameter int MAX_VALUES = 3
) (
  input  logic [gdl_pkg::OpW-1:0]           operation_i,
  input  logic [gdl_pkg::CountW-1:0]        value_count_i,
  input  logic signed [gdl_pkg::ValueW-1:0] value_a_i,
  input  logic signed [gdl_pkg::ValueW-1:0] value_b_i,
  input  logic signed [gdl_pkg::ValueW-1:0] value_c_i,
  output gdl_pkg::job_t                     job_o
);

  localparam int NumLanes = gdl_pkg::NumLanes;
  localparam int ValueW   = gdl_pkg::ValueW;
  localparam int CountW   = gdl_pkg::CountW;
  localparam int ProdW    = gdl_pkg::Recip10ProdW;
  localparam int IdxW     = gdl_pkg::IdxW;
  localparam int TenthW   = gdl_pkg::TenthW;
  localparam int FracW    = gdl_pkg::NumFracBits;
  localparam int OutW     = gdl_pkg::OutW;

  gdl_pkg::op_e             op;
  logic                     is_gl;
  logic [CountW-1:0]        count;
  logic [NumLanes-1:0]      used;
  logic signed [ValueW-1:0] vals [NumLanes];
  logic signed [ValueW-1:0] ref_val;
  logic [ValueW:0]          diff [NumLanes];
  logic [ValueW-1:0]        delta [NumLanes];
  logic [ProdW-1:0]         prod [NumLanes];
  logic [IdxW-1:0]          quo10 [NumLanes];
  logic [FracW-1:0]         rem10 [NumLanes];
  logic [CountW-1:0]        nonzero_cnt;
  logic [OutW-1:0]          gt_tenths;

  assign op    = gdl_pkg::op_e'(operation_i);
  assign is_gl = (op == gdl_pkg::OpGl);
  assign count = (value_count_i > CountW'(MAX_VALUES)) ? CountW'(MAX_VALUES) : value_count_i;

  assign vals[0] = value_a_i;
  assign vals[1] = value_b_i;
  assign vals[2] = value_c_i;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      used[i] = (i < int'(count));
    end
  end

  // PL is measured from the smallest value, GL from the largest.
  always_comb begin
    ref_val = vals[0];
    for (int i = 1; i < NumLanes; i++) begin
      if (used[i] && (is_gl ? (vals[i] > ref_val) : (vals[i] < ref_val))) begin
        ref_val = vals[i];
      end
    end
  end

  always_comb begin
    nonzero_cnt = '0;
    for (int i = 0; i < NumLanes; i++) begin
      diff[i] = is_gl ? ({ref_val[ValueW-1], ref_val} - {vals[i][ValueW-1], vals[i]})
                      : ({vals[i][ValueW-1], vals[i]} - {ref_val[ValueW-1], ref_val});
      delta[i] = diff[i][ValueW-1:0];
      // Divide the low eight bits of the phred distance by ten through the reciprocal; exact over that range.
      prod[i]  = ProdW'(delta[i][FracW-1:0]) * ProdW'(gdl_pkg::Recip10);
      quo10[i] = prod[i][gdl_pkg::Recip10Shift +: IdxW];
      rem10[i] = delta[i][FracW-1:0] - (FracW'(quo10[i]) << 3) - (FracW'(quo10[i]) << 1);
      nonzero_cnt = nonzero_cnt + CountW'(used[i] && (vals[i] != '0));
    end
  end

  assign gt_tenths = OutW'({nonzero_cnt, 3'b000}) + OutW'({nonzero_cnt, 1'b0});

  always_comb begin
    job_o = '0;
    for (int i = 0; i < NumLanes; i++) begin
      if (is_gl) begin
        job_o.live[i]      = used[i] && (delta[i] < ValueW'(gdl_pkg::GlLimit));
        job_o.int_idx[i]   = delta[i][FracW +: IdxW];
        job_o.tenth_idx[i] = '0;
        job_o.frac_bits[i] = delta[i][FracW-1:0];
      end else begin
        job_o.live[i]      = used[i] && (delta[i] < ValueW'(gdl_pkg::PlLimit));
        job_o.int_idx[i]   = quo10[i];
        job_o.tenth_idx[i] = rem10[i][TenthW-1:0];
        job_o.frac_bits[i] = '0;
      end
    end

    job_o.ctl.kind         = gdl_pkg::KindFixed;
    job_o.ctl.fixed_tenths = gdl_pkg::TenthsMissing;
    case (op)
      gdl_pkg::OpPl, gdl_pkg::OpGl: begin
        if (count != '0) begin
          job_o.ctl.kind = gdl_pkg::KindLikelihood;
        end
      end
      gdl_pkg::OpGt: begin
        if (count != '0) begin
          job_o.ctl.fixed_tenths = gt_tenths;
        end
      end
      gdl_pkg::OpMono: begin
        job_o.ctl.fixed_tenths = gdl_pkg::TenthsZero;
      end
      default: begin
        job_o.ctl.fixed_tenths = gdl_pkg::TenthsMissing;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/gdl_queue.sv =====
`default_nettype none

module gdl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  gdl_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output gdl_pkg::job_t pop_job_o
);

  localparam int Depth = gdl_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  gdl_pkg::job_t   slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = slots_q[rd_ptr_q];

  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/gdl_back.sv =====
`default_nettype none

module gdl_back #(
  parameter int WEIGHT_FRAC_BITS = 16,
  parameter int MAX_VALUES       = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  input  gdl_pkg::job_t                   job_i,
  output logic                            job_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [gdl_pkg::OutW-1:0] dosage_tenths_o
);

  localparam int AccW     = gdl_pkg::AccW;
  localparam int FracW    = gdl_pkg::NumFracBits;
  localparam int FracIdxW = gdl_pkg::FracIdxW;
  localparam int MulN     = gdl_pkg::NumMulStages;
  localparam int DivN     = gdl_pkg::NumDivBits;
  localparam int OutW     = gdl_pkg::OutW;

  localparam int WeightW  = WEIGHT_FRAC_BITS + 1;
  localparam int SumW     = WEIGHT_FRAC_BITS + 2;
  localparam int DvsW     = WEIGHT_FRAC_BITS + 3;
  localparam int RemW     = WEIGHT_FRAC_BITS + 7;
  localparam int RoundShift = gdl_pkg::AccFrac - WEIGHT_FRAC_BITS;
  localparam logic [AccW-1:0] RoundHalf = AccW'(1) << (RoundShift - 1);

  logic en;

  // Exponent chain: stage 0 applies the whole and tenth steps, stage m the fraction bit m-1.
  logic [MulN-1:0]   mul_vld_q;
  gdl_pkg::ctl_t     mul_ctl_q [MulN];
  logic [AccW-1:0]   acc_q [MulN][MAX_VALUES];
  logic [AccW-1:0]   acc_d [MulN][MAX_VALUES];
  logic [FracW-1:0]  frac_q [MulN][MAX_VALUES];

  logic              w_vld_q;
  gdl_pkg::ctl_t     w_ctl_q;
  logic [WeightW-1:0] w_q [MAX_VALUES];
  logic [WeightW-1:0] w_d [MAX_VALUES];

  logic              sum_vld_q;
  gdl_pkg::ctl_t     sum_ctl_q, sum_ctl_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [SumW-1:0]   num_q, num_d;

  // Restoring divider, one quotient bit per stage, most significant first.
  logic [DivN-1:0]   div_vld_q;
  gdl_pkg::ctl_t     div_ctl_q [DivN];
  logic [RemW-1:0]   rem_q [DivN];
  logic [DvsW-1:0]   dvs_q [DivN];
  logic [DivN-1:0]   quo_q [DivN];
  logic [RemW-1:0]   trial [DivN];
  logic [DivN-1:0]   ge;
  logic [RemW-1:0]   rem_d [DivN];
  logic [DivN-1:0]   quo_d [DivN];

  logic                   out_valid_q;
  logic signed [OutW-1:0] dosage_q, dosage_d;

  assign en          = !out_valid_q || out_ready_i;
  assign job_ready_o = en;

  always_comb begin
    for (int l = 0; l < MAX_VALUES; l++) begin
      acc_d[0][l] = job_i.live[l] ?
                    gdl_pkg::q30_mul(gdl_pkg::exp_int(job_i.int_idx[l]),
                                     gdl_pkg::exp_tenth(job_i.tenth_idx[l])) : '0;
      for (int m = 1; m < MulN; m++) begin
        acc_d[m][l] = frac_q[m-1][l][m-1] ?
                      gdl_pkg::q30_mul(acc_q[m-1][l], gdl_pkg::exp_bit(FracIdxW'(m - 1))) :
                      acc_q[m-1][l];
      end
      w_d[l] = WeightW'((acc_q[MulN-1][l] + RoundHalf) >> RoundShift);
    end
  end

  always_comb begin
    sum_d = '0;
    num_d = '0;
    for (int l = 0; l < MAX_VALUES; l++) begin
      sum_d = sum_d + SumW'(w_q[l]);
    end
    for (int l = 1; l < MAX_VALUES; l++) begin
      num_d = num_d + (SumW'(w_q[l]) << (l - 1));
    end
    sum_ctl_d = w_ctl_q;
    if (w_ctl_q.kind == gdl_pkg::KindLikelihood && sum_d == '0) begin
      sum_ctl_d.kind         = gdl_pkg::KindFixed;
      sum_ctl_d.fixed_tenths = gdl_pkg::TenthsMissing;
    end
  end

  always_comb begin
    for (int j = 0; j < DivN; j++) begin
      trial[j] = RemW'(dvs_q[j]) << (DivN - 1 - j);
      ge[j]    = (rem_q[j] >= trial[j]);
      rem_d[j] = ge[j] ? (rem_q[j] - trial[j]) : rem_q[j];
      quo_d[j] = quo_q[j] | (DivN'(ge[j]) << (DivN - 1 - j));
    end
    if (div_ctl_q[DivN-1].kind == gdl_pkg::KindLikelihood) begin
      dosage_d = OutW'(quo_d[DivN-1]);
    end else begin
      dosage_d = div_ctl_q[DivN-1].fixed_tenths;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q   <= '0;
      w_vld_q     <= 1'b0;
      sum_vld_q   <= 1'b0;
      div_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      mul_vld_q   <= {mul_vld_q[MulN-2:0], job_valid_i};
      w_vld_q     <= mul_vld_q[MulN-1];
      sum_vld_q   <= w_vld_q;
      div_vld_q   <= {div_vld_q[DivN-2:0], sum_vld_q};
      out_valid_q <= div_vld_q[DivN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_ctl_q[0] <= job_i.ctl;
      for (int m = 1; m < MulN; m++) begin
        mul_ctl_q[m] <= mul_ctl_q[m-1];
      end
      for (int l = 0; l < MAX_VALUES; l++) begin
        frac_q[0][l] <= job_i.frac_bits[l];
        for (int m = 1; m < MulN; m++) begin
          frac_q[m][l] <= frac_q[m-1][l];
        end
        for (int m = 0; m < MulN; m++) begin
          acc_q[m][l] <= acc_d[m][l];
        end
        w_q[l] <= w_d[l];
      end
      w_ctl_q <= mul_ctl_q[MulN-1];

      sum_ctl_q <= sum_ctl_d;
      sum_q     <= sum_d;
      num_q     <= num_d;

      // Dividend 20*num + sum over divisor 2*sum rounds ten times the ratio half up.
      div_ctl_q[0] <= sum_ctl_q;
      rem_q[0]     <= (RemW'(num_q) << 4) + (RemW'(num_q) << 2) + RemW'(sum_q);
      dvs_q[0]     <= DvsW'({sum_q, 1'b0});
      quo_q[0]     <= '0;
      for (int j = 1; j < DivN; j++) begin
        div_ctl_q[j] <= div_ctl_q[j-1];
        rem_q[j]     <= rem_d[j-1];
        dvs_q[j]     <= dvs_q[j-1];
        quo_q[j]     <= quo_d[j-1];
      end

      dosage_q <= dosage_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign dosage_tenths_o = dosage_q;

endmodule

`default_nettype wire
